@@ rtl/core/lps_pkg.sv @@
// Shared widths, codes and payload types for the line pixel stepper.
package lps_pkg;

	localparam int COORD_BITS = 12;
	localparam int ERR_BITS   = COORD_BITS + 2;
	localparam int COLOR_BITS = 32;

	localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

	// command codes
	localparam logic CMD_START = 1'b0;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [COLOR_BITS-1:0] color_t;
	typedef logic signed [ERR_BITS-1:0] err_t;

	typedef struct packed {
		logic   cmd;
		coord_t x_start;
		coord_t y_start;
		coord_t x_end;
		coord_t y_end;
		color_t start_color;
	} lps_item_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		color_t pixel_color;
		logic   last;
	} lps_pix_t;

	typedef struct packed {
		coord_t cur_x;
		coord_t cur_y;
		err_t   err_term;
		coord_t delta_major;
		coord_t delta_minor;
		coord_t steps_left;
		logic   x_is_major;
		logic   step_x_negative;
		logic   step_y_negative;
		color_t cur_color;
		logic   line_active;
	} lps_state_t;

endpackage

@@ rtl/core/lps_ifs.sv @@
// Valid/ready channel interfaces for line commands and emitted pixels.
interface lps_cmd_if import lps_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   cmd;
	coord_t x_start;
	coord_t y_start;
	coord_t x_end;
	coord_t y_end;
	color_t start_color;

	modport source (output valid, cmd, x_start, y_start, x_end, y_end, start_color,
		input ready);
	modport sink (input valid, cmd, x_start, y_start, x_end, y_end, start_color,
		output ready);
endinterface

interface lps_pix_if import lps_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t pixel_x;
	coord_t pixel_y;
	color_t pixel_color;
	logic   last;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

@@ rtl/core/lps_step.sv @@
// Next-state and pixel logic for one command beat of the Bresenham stepper.
module lps_step import lps_pkg::*; (
	input  lps_state_t st,
	input  lps_item_t  item,
	input  color_t     color_step,
	output lps_state_t st_next,
	output logic       has_pix,
	output lps_pix_t   pix
);
	logic   sxn, syn, x_major;
	coord_t dx, dy, dmaj, dmin, steps_dec;
	err_t   err_init, err_dmin2, err_diff2;
	coord_t mx, my;

	// line setup from the endpoints
	always_comb begin
		sxn      = item.x_end < item.x_start;
		syn      = item.y_end < item.y_start;
		dx       = sxn ? item.x_start - item.x_end : item.x_end - item.x_start;
		dy       = syn ? item.y_start - item.y_end : item.y_end - item.y_start;
		x_major  = dx > dy;
		dmaj     = x_major ? dx : dy;
		dmin     = x_major ? dy : dx;
		err_init = err_t'({1'b0, dmin, 1'b0}) - err_t'({2'b00, dmaj});
	end

	// error increments for a step on the stored line
	assign err_dmin2 = err_t'({1'b0, st.delta_minor, 1'b0});
	assign err_diff2 = err_dmin2 - err_t'({1'b0, st.delta_major, 1'b0});
	assign steps_dec = st.steps_left - COORD_ONE;

	always_comb begin
		st_next = st;
		has_pix = 1'b0;
		mx      = st.cur_x;
		my      = st.cur_y;
		if (item.cmd == CMD_START) begin
			st_next.step_x_negative = sxn;
			st_next.step_y_negative = syn;
			st_next.x_is_major      = x_major;
			st_next.delta_major     = dmaj;
			st_next.delta_minor     = dmin;
			st_next.err_term        = err_init;
			st_next.steps_left      = dmaj;
			st_next.cur_x           = item.x_start;
			st_next.cur_y           = item.y_start;
			st_next.cur_color       = item.start_color;
			st_next.line_active     = dmaj != '0;
			has_pix                 = 1'b1;
		end else if (st.line_active) begin
			// minor-axis move when the error is non-negative
			if (!st.err_term[ERR_BITS-1]) begin
				if (st.x_is_major)
					my = st.step_y_negative ? my - COORD_ONE : my + COORD_ONE;
				else
					mx = st.step_x_negative ? mx - COORD_ONE : mx + COORD_ONE;
				st_next.err_term = st.err_term + err_diff2;
			end else begin
				st_next.err_term = st.err_term + err_dmin2;
			end
			// major-axis move every step
			if (st.x_is_major)
				mx = st.step_x_negative ? mx - COORD_ONE : mx + COORD_ONE;
			else
				my = st.step_y_negative ? my - COORD_ONE : my + COORD_ONE;
			st_next.cur_x       = mx;
			st_next.cur_y       = my;
			st_next.cur_color   = st.cur_color - color_step;
			st_next.steps_left  = steps_dec;
			st_next.line_active = steps_dec != '0;
			has_pix             = 1'b1;
		end
	end

	assign pix.pixel_x     = st_next.cur_x;
	assign pix.pixel_y     = st_next.cur_y;
	assign pix.pixel_color = st_next.cur_color;
	assign pix.last        = st_next.steps_left == '0;
endmodule

@@ rtl/core/line_pixel_stepper.sv @@
// Bresenham line stepper top level: input stage, line state and pixel output register.
//
//  channel     dir   handshake          payload
//  cmd_chan    sink  valid/ready        cmd, x_start, y_start, x_end, y_end, start_color
//  pixel_chan  src   valid/ready        pixel_x, pixel_y, pixel_color, last
//  cfg         sink  cfg_we (no ready)  cfg_wdata -> color_step
//
// One command beat per cycle while cmd_chan.ready is high; each beat is registered in
// the input stage, then its pixel in the pixel register with the line-state update.
// The next-pixel add/compare on the stored line state sets the st_q feedback loop.
// arst_n clears the line state, color_step and both valid flags.
// A stalled pixel holds the input stage; cmd_chan.ready drops only while both are full.
module line_pixel_stepper import lps_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	lps_cmd_if.sink   cmd_chan,
	lps_pix_if.source pixel_chan,
	input  logic   cfg_we,
	input  color_t cfg_wdata
);
	logic       valid_s1;
	lps_item_t  item_s1;
	lps_state_t st_q, st_next;
	color_t     color_step_q;
	logic       out_valid_q;
	lps_pix_t   pix_q, pix;
	logic       has_pix, advance, in_ready;

	assign advance  = valid_s1 && (!out_valid_q || pixel_chan.ready);
	assign in_ready = !valid_s1 || advance;
	assign cmd_chan.ready = in_ready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			color_step_q <= '0;
		else if (cfg_we)
			color_step_q <= cfg_wdata;
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= cmd_chan.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && cmd_chan.valid) begin
			item_s1.cmd         <= cmd_chan.cmd;
			item_s1.x_start     <= cmd_chan.x_start;
			item_s1.y_start     <= cmd_chan.y_start;
			item_s1.x_end       <= cmd_chan.x_end;
			item_s1.y_end       <= cmd_chan.y_end;
			item_s1.start_color <= cmd_chan.start_color;
		end
	end

	lps_step u_step (
		.st         (st_q),
		.item       (item_s1),
		.color_step (color_step_q),
		.st_next    (st_next),
		.has_pix    (has_pix),
		.pix        (pix)
	);

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= '0;
		else if (advance)
			st_q <= st_next;
	end

	// pixel output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= has_pix;
		else if (pixel_chan.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && has_pix)
			pix_q <= pix;
	end

	assign pixel_chan.valid       = out_valid_q;
	assign pixel_chan.pixel_x     = pix_q.pixel_x;
	assign pixel_chan.pixel_y     = pix_q.pixel_y;
	assign pixel_chan.pixel_color = pix_q.pixel_color;
	assign pixel_chan.last        = pix_q.last;

	// checks
	a_start_emits: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.cmd == CMD_START |=> out_valid_q)
		else $error("start beat produced no pixel");

	a_idle_no_steps: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.line_active |-> st_q.steps_left == '0)
		else $error("idle line with steps left");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pix_q.last |-> !st_q.line_active)
		else $error("last pixel pending while line still active");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !pixel_chan.ready)
		else $error("input stalled without a full pipe");
endmodule

@@ verif/line_pixel_stepper_tb.sv @@
// Self-checking testbench for line_pixel_stepper: directed and random line traffic.
module line_pixel_stepper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lps_pkg::*;

	localparam logic CMD_ADVANCE = ~CMD_START;
	localparam int   COORD_MAX   = (1 << COORD_BITS) - 1;
	localparam int   MAX_PRINTED = 50;

	logic   clk;
	logic   arst_n;
	logic   cfg_we;
	color_t cfg_wdata;

	lps_cmd_if cmd_chan ();
	lps_pix_if pix_chan ();

	line_pixel_stepper u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_chan   (cmd_chan),
		.pixel_chan (pix_chan),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	// command beats waiting to be driven, pixels waiting to come out
	lps_item_t cmd_backlog[$];
	lps_pix_t  pending_pixels[$];

	int   sender_idle_pct;
	int   recv_stall_pct;
	int   mismatch_count;
	logic cmd_beat_taken;

	// line tracker: mirrors the rasterizer state
	coord_t ln_x, ln_y;
	err_t   ln_err;
	coord_t ln_major, ln_minor, ln_left;
	logic   ln_x_major, ln_neg_x, ln_neg_y, ln_active;
	color_t ln_color;
	color_t line_color_step;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	function automatic coord_t step_coord(input coord_t c, input logic neg);
		return neg ? c - COORD_ONE : c + COORD_ONE;
	endfunction

	function automatic void push_pixel();
		lps_pix_t px;
		px.pixel_x     = ln_x;
		px.pixel_y     = ln_y;
		px.pixel_color = ln_color;
		px.last        = (ln_left == '0);
		pending_pixels.push_back(px);
	endfunction

	// advance the tracked line by one accepted command beat
	task automatic trace_line_beat(input lps_item_t it);
		coord_t dx, dy;
		if (it.cmd == CMD_START) begin
			ln_neg_x   = it.x_end < it.x_start;
			ln_neg_y   = it.y_end < it.y_start;
			dx         = ln_neg_x ? it.x_start - it.x_end : it.x_end - it.x_start;
			dy         = ln_neg_y ? it.y_start - it.y_end : it.y_end - it.y_start;
			ln_x_major = dx > dy;
			ln_major   = ln_x_major ? dx : dy;
			ln_minor   = ln_x_major ? dy : dx;
			ln_err     = err_t'(2 * int'(ln_minor) - int'(ln_major));
			ln_left    = ln_major;
			ln_x       = it.x_start;
			ln_y       = it.y_start;
			ln_color   = it.start_color;
			ln_active  = (ln_left != '0);
			push_pixel();
		end else if (ln_active) begin
			ln_color = ln_color - line_color_step;
			if (ln_err >= 0) begin
				if (ln_x_major)
					ln_y = step_coord(ln_y, ln_neg_y);
				else
					ln_x = step_coord(ln_x, ln_neg_x);
				ln_err = err_t'(int'(ln_err) + 2 * (int'(ln_minor) - int'(ln_major)));
			end else begin
				ln_err = err_t'(int'(ln_err) + 2 * int'(ln_minor));
			end
			if (ln_x_major)
				ln_x = step_coord(ln_x, ln_neg_x);
			else
				ln_y = step_coord(ln_y, ln_neg_y);
			ln_left = ln_left - COORD_ONE;
			if (ln_left == '0)
				ln_active = 1'b0;
			push_pixel();
		end
	endtask

	task automatic check_pixel(input lps_pix_t got);
		lps_pix_t want;
		if (pending_pixels.size() == 0) begin
			flag_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%h last=%b",
				got.pixel_x, got.pixel_y, got.pixel_color, got.last));
			return;
		end
		want = pending_pixels.pop_front();
		if (got.pixel_x !== want.pixel_x)
			flag_mismatch($sformatf("pixel_x got %0d want %0d", got.pixel_x, want.pixel_x));
		if (got.pixel_y !== want.pixel_y)
			flag_mismatch($sformatf("pixel_y got %0d want %0d", got.pixel_y, want.pixel_y));
		if (got.pixel_color !== want.pixel_color)
			flag_mismatch($sformatf("pixel_color got %h want %h",
				got.pixel_color, want.pixel_color));
		if (got.last !== want.last)
			flag_mismatch($sformatf("last got %b want %b at x=%0d y=%0d",
				got.last, want.last, want.pixel_x, want.pixel_y));
	endtask

	// command driver: new beat only once the previous one has been taken
	always @(negedge clk) begin : drive_cmd
		lps_item_t nxt;
		logic      drive;
		if (arst_n) begin
			if (!cmd_chan.valid || cmd_beat_taken) begin
				drive = 1'b0;
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					nxt   = cmd_backlog.pop_front();
					drive = 1'b1;
					cmd_chan.cmd         <= nxt.cmd;
					cmd_chan.x_start     <= nxt.x_start;
					cmd_chan.y_start     <= nxt.y_start;
					cmd_chan.x_end       <= nxt.x_end;
					cmd_chan.y_end       <= nxt.y_end;
					cmd_chan.start_color <= nxt.start_color;
				end
				cmd_chan.valid <= drive;
			end
			pix_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: register writes, pixel beats, accepted command beats
	always @(posedge clk) begin : watch_beats
		lps_item_t it;
		lps_pix_t  got;
		if (!arst_n) begin
			cmd_beat_taken <= 1'b0;
		end else begin
			cmd_beat_taken <= cmd_chan.valid && cmd_chan.ready;
			if (cfg_we)
				line_color_step = cfg_wdata;
			if (pix_chan.valid && pix_chan.ready) begin
				got.pixel_x     = pix_chan.pixel_x;
				got.pixel_y     = pix_chan.pixel_y;
				got.pixel_color = pix_chan.pixel_color;
				got.last        = pix_chan.last;
				check_pixel(got);
			end
			if (cmd_chan.valid && cmd_chan.ready) begin
				it.cmd         = cmd_chan.cmd;
				it.x_start     = cmd_chan.x_start;
				it.y_start     = cmd_chan.y_start;
				it.x_end       = cmd_chan.x_end;
				it.y_end       = cmd_chan.y_end;
				it.start_color = cmd_chan.start_color;
				trace_line_beat(it);
			end
		end
	end

	function automatic int clamp_coord(input int v);
		return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
	endfunction

	// mostly random, sometimes pinned to the border of the raster
	function automatic int edge_coord();
		int roll;
		roll = $urandom_range(9);
		return (roll == 0) ? 0 : ((roll == 1) ? COORD_MAX : $urandom_range(COORD_MAX));
	endfunction

	function automatic lps_item_t advance_beat();
		lps_item_t it;
		it.cmd         = CMD_ADVANCE;
		it.x_start     = coord_t'($urandom);
		it.y_start     = coord_t'($urandom);
		it.x_end       = coord_t'($urandom);
		it.y_end       = coord_t'($urandom);
		it.start_color = $urandom;
		return it;
	endfunction

	// start beat, then walk advances, then extra advances past the end
	task automatic queue_line(input int xs, input int ys, input int xe, input int ye,
		input color_t color, input int walk, input int extra);
		lps_item_t it;
		it.cmd         = CMD_START;
		it.x_start     = coord_t'(xs);
		it.y_start     = coord_t'(ys);
		it.x_end       = coord_t'(xe);
		it.y_end       = coord_t'(ye);
		it.start_color = color;
		cmd_backlog.push_back(it);
		repeat (walk + extra) cmd_backlog.push_back(advance_beat());
	endtask

	task automatic queue_mixed_traffic(input int budget);
		int made, xs, ys, xe, ye, span, major, walk, extra, roll;
		made = 0;
		while (made < budget) begin
			roll = $urandom_range(99);
			if (roll < 6) begin
				// long line, dropped partway by the next start
				walk = $urandom_range(60, 1);
				queue_line($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
					$urandom_range(COORD_MAX), $urandom_range(COORD_MAX), $urandom, walk, 0);
				made += walk + 1;
			end else if (roll < 10) begin
				// stray advances, ignored when no line is open
				repeat ($urandom_range(3, 1)) cmd_backlog.push_back(advance_beat());
			end else begin
				xs    = edge_coord();
				ys    = edge_coord();
				span  = ($urandom_range(99) < 85) ? 12 : 80;
				xe    = clamp_coord(xs + int'($urandom_range(2 * span)) - span);
				ye    = clamp_coord(ys + int'($urandom_range(2 * span)) - span);
				major = (xe > xs) ? xe - xs : xs - xe;
				if (((ye > ys) ? ye - ys : ys - ye) > major)
					major = (ye > ys) ? ye - ys : ys - ye;
				walk  = major;
				extra = 0;
				roll  = $urandom_range(99);
				if (roll < 15)
					walk = $urandom_range(major);
				else if (roll < 35)
					extra = $urandom_range(3, 1);
				queue_line(xs, ys, xe, ye, $urandom, walk, extra);
				made += walk + 1;
			end
		end
	endtask

	// sender stops until every pixel is out and the pipe has gone quiet
	task automatic wait_for_idle_block();
		while (cmd_backlog.size() != 0 || cmd_chan.valid || pending_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_color_step(input color_t value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input int sidle, input int rstall, input color_t step);
		set_color_step(step);
		sender_idle_pct = sidle;
		recv_stall_pct  = rstall;
		queue_mixed_traffic(150);
		wait_for_idle_block();
		queue_mixed_traffic(150);
		wait_for_idle_block();
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		cmd_chan.valid       = 1'b0;
		cmd_chan.cmd         = CMD_START;
		cmd_chan.x_start     = '0;
		cmd_chan.y_start     = '0;
		cmd_chan.x_end       = '0;
		cmd_chan.y_end       = '0;
		cmd_chan.start_color = '0;
		pix_chan.ready       = 1'b0;
		sender_idle_pct      = 0;
		recv_stall_pct       = 0;
		mismatch_count       = 0;
		line_color_step      = '0;
		ln_x = '0; ln_y = '0; ln_err = '0;
		ln_major = '0; ln_minor = '0; ln_left = '0;
		ln_x_major = 1'b0; ln_neg_x = 1'b0; ln_neg_y = 1'b0;
		ln_color = '0; ln_active = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed lines
		set_color_step(color_t'(1));
		cmd_backlog.push_back(advance_beat());                          // idle after reset
		queue_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, '1, 0, 1); // zero length
		queue_line(0, 0, 3, 1, '0, 3, 0);                               // x major, color wraps
		queue_line(10, 10, 7, 13, $urandom, 3, 0);                      // tie goes to y
		queue_line(5, 9, 5, 5, $urandom, 4, 0);                         // vertical, y down
		queue_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX, $urandom, 2, 0);
		queue_line(0, 0, COORD_MAX, COORD_MAX, $urandom, 2, 0);         // restarted below
		queue_line(COORD_MAX, 0, 0, 2, $urandom, 2, 0);
		wait_for_idle_block();

		run_phase(0, 0, '1);
		run_phase(65, 0, '0);
		run_phase(0, 65, 32'h8000_0000);
		run_phase(23, 23, $urandom);
		run_phase(0, 0, $urandom);

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// hang guard
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/lps_pkg.sv
rtl/core/lps_ifs.sv
rtl/core/lps_step.sv
rtl/core/line_pixel_stepper.sv
verif/line_pixel_stepper_tb.sv
